@@ rtl/qurm_pkg.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model package
// Shared widths, codes, reset values and the types passed between the front
// end, the decoded-op queue and the execution back end.
// ----------------------------------------------------------------------------
package qurm_pkg;

  localparam int unsigned UNIT_COUNT         = 4;
  localparam int unsigned UNIT_W             = 2;
  localparam int unsigned ADDR_W             = 16;
  localparam int unsigned WDATA_W            = 16;
  localparam int unsigned RDATA_W            = 16;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 16;
  localparam int unsigned DRAIN_W            = 8;
  localparam int unsigned BACKLOG_W          = 16;
  localparam int unsigned IRQ_W              = 2;
  localparam int unsigned DEFAULT_FIFO_DEPTH = 16;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [ADDR_W-1:0]    BASE_MASK     = 16'hfff8;
  localparam logic [BYTE_W-1:0]    LSR_RESET     = 8'h60;
  localparam logic [BYTE_W-1:0]    SCRATCH_RESET = 8'hff;
  localparam logic [BYTE_W-1:0]    LSR_THR_EMPTY = 8'h60;
  localparam logic [BYTE_W-1:0]    LSR_THR_CLEAR = 8'h9f;
  localparam logic [BYTE_W-1:0]    LSR_OE_CLEAR  = 8'hfd;
  localparam logic [BYTE_W-1:0]    LSR_OE        = 8'h02;
  localparam logic [BYTE_W-1:0]    LSR_DR        = 8'h01;
  localparam logic [BYTE_W-1:0]    LSR_DR_CLEAR  = 8'hfe;
  localparam logic [BYTE_W-1:0]    ISR_RX        = 8'hc4;
  localparam logic [BYTE_W-1:0]    ISR_TX        = 8'hc2;
  localparam logic [BYTE_W-1:0]    ISR_NONE      = 8'hc1;
  localparam logic [RDATA_W-1:0]   RD_EMPTY      = 16'hffff;
  localparam logic [BACKLOG_W-1:0] BACKLOG_MAX   = 16'hffff;

  localparam logic [UNIT_COUNT-1:0][ADDR_W-1:0] BASE_RESET =
    {16'd40, 16'd32, 16'd24, 16'd16};
  localparam logic [UNIT_COUNT-1:0] RX_MASK_RESET = 4'h1;
  localparam logic [DRAIN_W-1:0]    DRAIN_RESET   = 8'd16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RX    = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_MISS  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_RX    = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    OFS_DATA = 3'd0,
    OFS_IER  = 3'd1,
    OFS_ISR  = 3'd2,
    OFS_LCR  = 3'd3,
    OFS_MCR  = 3'd4,
    OFS_LSR  = 3'd5,
    OFS_MSR  = 3'd6,
    OFS_SCR  = 3'd7
  } ofs_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT0_BASE = 3'd0,
    CFG_UNIT1_BASE = 3'd1,
    CFG_UNIT2_BASE = 3'd2,
    CFG_UNIT3_BASE = 3'd3,
    CFG_RX_MASK    = 3'd4,
    CFG_DRAIN      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [UNIT_COUNT-1:0][ADDR_W-1:0] base;
    logic [UNIT_COUNT-1:0]             rx_mask;
    logic [DRAIN_W-1:0]                drain;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [UNIT_W-1:0] unit;
    ofs_e              ofs;
    logic [BYTE_W-1:0] data;
  } op_t;

  typedef struct packed {
    logic               accepted;
    logic [RDATA_W-1:0] read_data;
    logic               tx_valid;
    logic [UNIT_W-1:0]  tx_unit;
    logic [BYTE_W-1:0]  tx_byte;
    logic [IRQ_W-1:0]   irq;
    logic               pop;
    logic [UNIT_W-1:0]  pop_unit;
  } res_t;

endpackage

@@ rtl/qurm_if.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model channels
// Valid/ready request and response channels with their item payloads.
// ----------------------------------------------------------------------------
interface qurm_req_if import qurm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [ADDR_W-1:0]  address;
  logic [WDATA_W-1:0] write_data;
  logic [BYTE_W-1:0]  rx_byte;

  modport source (output valid, command, address, write_data, rx_byte, input ready);
  modport sink   (input valid, command, address, write_data, rx_byte, output ready);
endinterface

interface qurm_rsp_if import qurm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [RDATA_W-1:0] read_data;
  logic               tx_valid;
  logic [UNIT_W-1:0]  tx_unit;
  logic [BYTE_W-1:0]  tx_byte;
  logic [IRQ_W-1:0]   irq_pulse;

  modport source (output valid, accepted, read_data, tx_valid, tx_unit, tx_byte,
                  irq_pulse, input ready);
  modport sink   (input valid, accepted, read_data, tx_valid, tx_unit, tx_byte,
                  irq_pulse, output ready);
endinterface

@@ rtl/quad_uart_register_model_core.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model core
// Four 16550-style register sets sharing one bus, with receive stores,
// transmit backlog counters and interrupt pulses.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: bus write, bus read, received byte
//   or tick. rsp returns exactly one result item per request item, in order.
//   cfg_we_i/cfg_index_i/cfg_wdata_i write the unit bases, the receive mask
//   and the drain per tick; write them only while no item is in flight.
// Path: an accepted item waits in the op queue; the back end executes it once
//   it is at the queue head and the output register can take its result,
//   which is registered there and presented on rsp.
// Throughput: one item per cycle while rsp.ready stays high; the back end
//   runs one op per cycle, limited by the per-unit register read-modify-write
//   and the single read port of each receive store.
// Reset: all unit registers take their reset values, the op queue and the
//   output register empty; receive store contents are left as they are.
// Stall: when rsp.ready is low the result is held, the back end stops and the
//   two-entry op queue fills; req.ready drops once it is full.
// ----------------------------------------------------------------------------
module quad_uart_register_model_core import qurm_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  qurm_req_if.sink              req,
  qurm_rsp_if.source            rsp
);

  cfg_t cfg_q;
  logic push, q_full, q_valid, q_pop;
  op_t  op_in, op_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base    <= BASE_RESET;
      cfg_q.rx_mask <= RX_MASK_RESET;
      cfg_q.drain   <= DRAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UNIT0_BASE: cfg_q.base[0] <= cfg_wdata_i;
        CFG_UNIT1_BASE: cfg_q.base[1] <= cfg_wdata_i;
        CFG_UNIT2_BASE: cfg_q.base[2] <= cfg_wdata_i;
        CFG_UNIT3_BASE: cfg_q.base[3] <= cfg_wdata_i;
        CFG_RX_MASK:    cfg_q.rx_mask <= cfg_wdata_i[UNIT_COUNT-1:0];
        CFG_DRAIN:      cfg_q.drain   <= cfg_wdata_i[DRAIN_W-1:0];
        default: ;
      endcase
    end
  end

  qurm_front u_front (
    .req      (req),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (op_in)
  );

  qurm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (op_out)
  );

  qurm_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (q_valid),
    .op_i       (op_out),
    .op_pop_o   (q_pop),
    .rsp        (rsp)
  );

endmodule

@@ rtl/qurm_front.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model front end
// Takes request items, matches the bus address against the unit bases and
// classifies each item into a decoded op for the queue.
// ----------------------------------------------------------------------------
module qurm_front import qurm_pkg::*; (
  qurm_req_if.sink req,
  input  cfg_t     cfg_i,
  input  logic     q_full_i,
  output logic     push_o,
  output op_t      op_o
);

  logic              hit;
  logic [UNIT_W-1:0] hit_unit;
  logic [ADDR_W-1:0] addr_aligned;

  assign req.ready    = !q_full_i;
  assign push_o       = req.valid && !q_full_i;
  assign addr_aligned = req.address & BASE_MASK;

  // lowest matching unit wins
  always_comb begin
    hit      = 1'b0;
    hit_unit = '0;
    for (int u = UNIT_COUNT - 1; u >= 0; u--) begin
      if (cfg_i.base[u] == addr_aligned) begin
        hit      = 1'b1;
        hit_unit = UNIT_W'(u);
      end
    end
  end

  always_comb begin
    op_o      = '0;
    op_o.op   = OP_MISS;
    op_o.unit = hit_unit;
    op_o.ofs  = ofs_e'(req.address[2:0]);
    op_o.data = req.write_data[BYTE_W-1:0];
    unique case (cmd_e'(req.command))
      CMD_WRITE: op_o.op = hit ? OP_WRITE : OP_MISS;
      CMD_READ:  op_o.op = hit ? OP_READ : OP_MISS;
      CMD_RX: begin
        op_o.op   = OP_RX;
        op_o.data = req.rx_byte;
      end
      CMD_TICK:  op_o.op = OP_TICK;
    endcase
  end

endmodule

@@ rtl/qurm_queue.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model op queue
// Short FIFO of decoded ops between the front end and the back end.
// ----------------------------------------------------------------------------
module qurm_queue import qurm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  localparam int unsigned QP_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  op_t             slot_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QC_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QC_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QP_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ rtl/qurm_back.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model back end
// Executes one decoded op per cycle while the output register is free or being
// emptied, against the per-unit register state and receive stores, and holds
// the result item in that output register.
module qurm_back import qurm_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic op_valid_i,
  input  op_t  op_i,
  output logic op_pop_o,
  qurm_rsp_if.source rsp
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_S   = (PTR_W + 1)'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] HEAD_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL  = LVL_W'(FIFO_DEPTH);

  logic [BYTE_W-1:0]    ier_q [UNIT_COUNT], ier_d [UNIT_COUNT];
  logic [BYTE_W-1:0]    lcr_q [UNIT_COUNT], lcr_d [UNIT_COUNT];
  logic [BYTE_W-1:0]    mcr_q [UNIT_COUNT], mcr_d [UNIT_COUNT];
  logic [BYTE_W-1:0]    lsr_q [UNIT_COUNT], lsr_d [UNIT_COUNT];
  logic [BYTE_W-1:0]    scr_q [UNIT_COUNT], scr_d [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] rxf_q, rxf_d, txf_q, txf_d;
  logic [BACKLOG_W-1:0] backlog_q [UNIT_COUNT], backlog_d [UNIT_COUNT];
  logic [PTR_W-1:0]     head_q [UNIT_COUNT], head_d [UNIT_COUNT];
  logic [LVL_W-1:0]     level_q [UNIT_COUNT], level_d [UNIT_COUNT];

  logic [UNIT_COUNT-1:0] wr_en, rd_en;
  logic [PTR_W-1:0]      wr_slot [UNIT_COUNT];
  logic [BYTE_W-1:0]     rd_q [UNIT_COUNT];
  logic [IRQ_W-1:0]      irq_v;

  logic fire;
  logic s1_valid_q;
  res_t s1_q, res_d;

  assign fire     = op_valid_i && (!s1_valid_q || rsp.ready);
  assign op_pop_o = fire;

  // per-unit state update
  always_comb begin
    logic              sel;
    logic [PTR_W:0]    slot_sum;
    logic [BACKLOG_W-1:0] drain_ext;
    ier_d     = ier_q;
    lcr_d     = lcr_q;
    mcr_d     = mcr_q;
    lsr_d     = lsr_q;
    scr_d     = scr_q;
    rxf_d     = rxf_q;
    txf_d     = txf_q;
    backlog_d = backlog_q;
    head_d    = head_q;
    level_d   = level_q;
    wr_en     = '0;
    rd_en     = '0;
    irq_v     = '0;
    sel       = 1'b0;
    drain_ext = {{(BACKLOG_W - DRAIN_W){1'b0}}, cfg_i.drain};
    for (int u = 0; u < UNIT_COUNT; u++) begin
      sel      = fire && (op_i.unit == UNIT_W'(u));
      slot_sum = {1'b0, head_q[u]} + {1'b0, level_q[u][PTR_W-1:0]};
      wr_slot[u] = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S) : slot_sum[PTR_W-1:0];
      case (op_i.op)
        OP_WRITE: begin
          if (sel) begin
            unique case (op_i.ofs)
              OFS_DATA: begin
                if (!lcr_q[u][7] && ier_q[u][1]) begin
                  if (backlog_q[u] != BACKLOG_MAX) begin
                    backlog_d[u] = backlog_q[u] + BACKLOG_W'(1);
                  end
                  lsr_d[u] = lsr_q[u] & LSR_THR_CLEAR;
                end
              end
              OFS_IER: begin
                if (!lcr_q[u][7]) begin
                  ier_d[u] = op_i.data;
                end
              end
              OFS_LCR: lcr_d[u] = op_i.data;
              OFS_MCR: mcr_d[u] = op_i.data;
              OFS_SCR: scr_d[u] = op_i.data;
              OFS_ISR, OFS_LSR, OFS_MSR: ;
            endcase
          end
        end
        OP_READ: begin
          if (sel) begin
            if (op_i.ofs == OFS_DATA) begin
              if (level_q[u] != '0) begin
                rd_en[u]   = 1'b1;
                head_d[u]  = (head_q[u] == HEAD_LAST) ? '0 : head_q[u] + PTR_W'(1);
                level_d[u] = level_q[u] - LVL_W'(1);
              end
              if (level_q[u] <= LVL_W'(1)) begin
                lsr_d[u] = lsr_q[u] & LSR_DR_CLEAR;
              end
            end else if (op_i.ofs == OFS_ISR) begin
              if (rxf_q[u]) begin
                rxf_d[u] = 1'b0;
              end else if (txf_q[u]) begin
                txf_d[u] = 1'b0;
              end
            end
          end
        end
        OP_RX: begin
          if (fire && cfg_i.rx_mask[u]) begin
            if (level_q[u] == LVL_FULL) begin
              lsr_d[u] = lsr_q[u] | LSR_OE;
            end else begin
              lsr_d[u]   = (lsr_q[u] & LSR_OE_CLEAR) | LSR_DR;
              wr_en[u]   = 1'b1;
              level_d[u] = level_q[u] + LVL_W'(1);
            end
            if (ier_q[u][0]) begin
              rxf_d[u] = 1'b1;
              irq_v[u / 2] = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (fire && backlog_q[u] != '0) begin
            backlog_d[u] = (backlog_q[u] > drain_ext) ? backlog_q[u] - drain_ext : '0;
            if (backlog_d[u] == '0) begin
              txf_d[u] = 1'b1;
              lsr_d[u] = lsr_q[u] | LSR_THR_EMPTY;
              irq_v[u / 2] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result item
  always_comb begin
    logic [UNIT_W-1:0] cu;
    cu           = op_i.unit;
    res_d        = '0;
    res_d.pop_unit = cu;
    case (op_i.op)
      OP_WRITE: begin
        res_d.accepted = 1'b1;
        if (op_i.ofs == OFS_DATA && !lcr_q[cu][7]) begin
          res_d.tx_valid = 1'b1;
          res_d.tx_unit  = cu;
          res_d.tx_byte  = op_i.data;
        end
      end
      OP_READ: begin
        res_d.accepted = 1'b1;
        unique case (op_i.ofs)
          OFS_DATA: begin
            if (level_q[cu] != '0) begin
              res_d.pop = 1'b1;
            end else begin
              res_d.read_data = RD_EMPTY;
            end
          end
          OFS_IER: res_d.read_data = {8'h00, ier_q[cu]};
          OFS_ISR: begin
            if (rxf_q[cu]) begin
              res_d.read_data = {8'h00, ISR_RX};
            end else if (txf_q[cu]) begin
              res_d.read_data = {8'h00, ISR_TX};
            end else begin
              res_d.read_data = {8'h00, ISR_NONE};
            end
          end
          OFS_LCR: res_d.read_data = {8'h00, lcr_q[cu]};
          OFS_MCR: res_d.read_data = {8'h00, mcr_q[cu]};
          OFS_LSR: res_d.read_data = {8'h00, lsr_q[cu]};
          OFS_MSR: res_d.read_data = '0;
          OFS_SCR: res_d.read_data = {8'h00, scr_q[cu]};
        endcase
      end
      OP_RX, OP_TICK: res_d.irq = irq_v;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ier_q      <= '{default: '0};
      lcr_q      <= '{default: '0};
      mcr_q      <= '{default: '0};
      lsr_q      <= '{default: LSR_RESET};
      scr_q      <= '{default: SCRATCH_RESET};
      rxf_q      <= '0;
      txf_q      <= '0;
      backlog_q  <= '{default: '0};
      head_q     <= '{default: '0};
      level_q    <= '{default: '0};
      s1_valid_q <= 1'b0;
    end else begin
      ier_q     <= ier_d;
      lcr_q     <= lcr_d;
      mcr_q     <= mcr_d;
      lsr_q     <= lsr_d;
      scr_q     <= scr_d;
      rxf_q     <= rxf_d;
      txf_q     <= txf_d;
      backlog_q <= backlog_d;
      head_q    <= head_d;
      level_q   <= level_d;
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q <= res_d;
    end
  end

  // receive store, one per unit
  for (genvar g = 0; g < UNIT_COUNT; g++) begin : g_store
    logic [BYTE_W-1:0] mem [FIFO_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        mem[wr_slot[g]] <= op_i.data;
      end
      if (rd_en[g]) begin
        rd_q[g] <= mem[head_q[g]];
      end
    end
  end

  assign rsp.valid     = s1_valid_q;
  assign rsp.accepted  = s1_q.accepted;
  assign rsp.read_data = s1_q.pop ? {8'h00, rd_q[s1_q.pop_unit]} : s1_q.read_data;
  assign rsp.tx_valid  = s1_q.tx_valid;
  assign rsp.tx_unit   = s1_q.tx_unit;
  assign rsp.tx_byte   = s1_q.tx_byte;
  assign rsp.irq_pulse = s1_q.irq;

  for (genvar a = 0; a < UNIT_COUNT; a++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      level_q[a] <= LVL_FULL)
      else $error("receive level above depth");
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      lsr_q[a][0] == (level_q[a] != '0))
      else $error("data-ready bit out of step with receive level");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_q.tx_valid || s1_q.pop) |-> s1_q.accepted)
    else $error("transmit or pop without a bus hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_q.irq != '0) |-> !s1_q.accepted && !s1_q.pop)
    else $error("interrupt pulse on a bus access item");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Quad UART register model testbench
// Drives bus writes, bus reads, received bytes and ticks into the core over
// valid/ready channels with random gaps and stalls, and checks every result
// item against a pinned value or a cycle-free model of the four register
// sets. A fixed table covers reset values and the corner cases; filled FIFOs,
// a drained transmit backlog, a zero drain and several unit layouts follow,
// then random traffic under each layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import qurm_pkg::*;

  localparam int FIFO_DEPTH     = DEFAULT_FIFO_DEPTH;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_WAIT    = 8;
  localparam int HOLD_CYCLES    = 120;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 92;
  localparam int BACKLOG_WRITES = 40;
  localparam int DRAIN_TICKS    = 8;

  typedef struct packed {
    cmd_e               command;
    logic [ADDR_W-1:0]  address;
    logic [WDATA_W-1:0] write_data;
    logic [BYTE_W-1:0]  rx_byte;
  } bus_item_t;

  typedef struct packed {
    logic               accepted;
    logic [RDATA_W-1:0] read_data;
    logic               tx_valid;
    logic [UNIT_W-1:0]  tx_unit;
    logic [BYTE_W-1:0]  tx_byte;
    logic [IRQ_W-1:0]   irq;
  } uart_result_t;

  typedef struct packed {
    bus_item_t    item;
    logic         pinned;
    uart_result_t want;
  } stim_row_t;

  // reset layout: unit 0 at 0x10, unit 3 at 0x28
  localparam stim_row_t DIRECTED_ROWS [28] = '{
    '{'{CMD_READ,  'h0011, 'h0000, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0015, 'h0000, 'h00}, 1'b1, '{1'b1, 'h0060, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0017, 'h0000, 'h00}, 1'b1, '{1'b1, 'h00ff, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0012, 'h0000, 'h00}, 1'b1, '{1'b1, 'h00c1, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0010, 'h0000, 'h00}, 1'b1, '{1'b1, 'hffff, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0016, 'h0000, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'hffff, 'hffff, 'hff}, 1'b1, '{1'b0, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0000, 'h0000, 'h00}, 1'b1, '{1'b0, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0017, 'hff00, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0017, 'h0000, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0011, 'h0003, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_RX,    'h0000, 'h0000, 'ha5}, 1'b1, '{1'b0, 'h0000, 1'b0, 'd0, 'h00, 'd1}},
    '{'{CMD_READ,  'h0012, 'h0000, 'h00}, 1'b1, '{1'b1, 'h00c4, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0015, 'h0000, 'h00}, 1'b0, '0},
    '{'{CMD_READ,  'h0010, 'h0000, 'h00}, 1'b0, '0},
    '{'{CMD_WRITE, 'h0010, 'hab5a, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b1, 'd0, 'h5a, 'd0}},
    '{'{CMD_TICK,  'h0000, 'h0000, 'h00}, 1'b1, '{1'b0, 'h0000, 1'b0, 'd0, 'h00, 'd1}},
    '{'{CMD_READ,  'h0012, 'h0000, 'h00}, 1'b1, '{1'b1, 'h00c2, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0013, 'h0080, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0010, 'h0077, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0011, 'h0000, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0011, 'h0000, 'h00}, 1'b0, '0},
    '{'{CMD_WRITE, 'h002c, 'h001f, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h0028, 'h00ff, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b1, 'd3, 'hff, 'd0}},
    '{'{CMD_WRITE, 'h001a, 'hffff, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_WRITE, 'h001d, 'hffff, 'h00}, 1'b1, '{1'b1, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_TICK,  'h0000, 'h0000, 'h00}, 1'b1, '{1'b0, 'h0000, 1'b0, 'd0, 'h00, 'd0}},
    '{'{CMD_READ,  'h0013, 'h0000, 'h00}, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  qurm_req_if req ();
  qurm_rsp_if rsp ();

  quad_uart_register_model_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [ADDR_W-1:0]     cur_base [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] cur_mask;
  logic [DRAIN_W-1:0]    cur_drain;
  logic [BYTE_W-1:0]     ier_r [UNIT_COUNT];
  logic [BYTE_W-1:0]     lcr_r [UNIT_COUNT];
  logic [BYTE_W-1:0]     mcr_r [UNIT_COUNT];
  logic [BYTE_W-1:0]     lsr_r [UNIT_COUNT];
  logic [BYTE_W-1:0]     scr_r [UNIT_COUNT];
  bit                    rx_flag [UNIT_COUNT];
  bit                    tx_flag [UNIT_COUNT];
  logic [BACKLOG_W-1:0]  backlog [UNIT_COUNT];
  logic [BYTE_W-1:0]     rx_mem [UNIT_COUNT][FIFO_DEPTH];
  int                    rx_rd [UNIT_COUNT];
  int                    rx_cnt [UNIT_COUNT];

  uart_result_t pending_results [$];
  bit src_idle;
  bit sink_idle;
  bit hold_req;
  int errors;
  int items_sent;
  int results_seen;
  int overruns;
  int irq_pulses;
  int config_count;

  function automatic uart_result_t predict_uart_result(input bus_item_t it);
    uart_result_t r;
    int hit;
    int slot;
    logic [UNIT_W-1:0] u;
    ofs_e ofs;
    logic [BYTE_W-1:0] d;
    bit dlab;
    r = '0;
    hit = -1;
    d = it.write_data[BYTE_W-1:0];
    ofs = ofs_e'(it.address[2:0]);
    case (it.command)
      CMD_WRITE, CMD_READ: begin
        for (int i = UNIT_COUNT - 1; i >= 0; i--) begin
          if (cur_base[i] == (it.address & BASE_MASK)) hit = i;
        end
        if (hit >= 0) begin
          u = UNIT_W'(hit);
          dlab = lcr_r[u][7];
          r.accepted = 1'b1;
          if (it.command == CMD_WRITE) begin
            case (ofs)
              OFS_DATA: begin
                if (!dlab) begin
                  r.tx_valid = 1'b1;
                  r.tx_unit = u;
                  r.tx_byte = d;
                  if (ier_r[u][1]) begin
                    if (backlog[u] != BACKLOG_MAX) backlog[u]++;
                    lsr_r[u] &= LSR_THR_CLEAR;
                  end
                end
              end
              OFS_IER: if (!dlab) ier_r[u] = d;
              OFS_LCR: lcr_r[u] = d;
              OFS_MCR: mcr_r[u] = d;
              OFS_SCR: scr_r[u] = d;
              default: ;
            endcase
          end else begin
            case (ofs)
              OFS_DATA: begin
                if (rx_cnt[u] != 0) begin
                  r.read_data = RDATA_W'(rx_mem[u][rx_rd[u]]);
                  rx_rd[u] = (rx_rd[u] + 1) % FIFO_DEPTH;
                  rx_cnt[u]--;
                end else begin
                  r.read_data = RD_EMPTY;
                end
                if (rx_cnt[u] == 0) lsr_r[u] &= LSR_DR_CLEAR;
              end
              OFS_IER: r.read_data = RDATA_W'(ier_r[u]);
              OFS_ISR: begin
                if (rx_flag[u]) begin
                  r.read_data = RDATA_W'(ISR_RX);
                  rx_flag[u] = 1'b0;
                end else if (tx_flag[u]) begin
                  r.read_data = RDATA_W'(ISR_TX);
                  tx_flag[u] = 1'b0;
                end else begin
                  r.read_data = RDATA_W'(ISR_NONE);
                end
              end
              OFS_LCR: r.read_data = RDATA_W'(lcr_r[u]);
              OFS_MCR: r.read_data = RDATA_W'(mcr_r[u]);
              OFS_LSR: r.read_data = RDATA_W'(lsr_r[u]);
              OFS_MSR: r.read_data = '0;
              default: r.read_data = RDATA_W'(scr_r[u]);
            endcase
          end
        end
      end
      CMD_RX: begin
        for (int i = 0; i < UNIT_COUNT; i++) begin
          if (cur_mask[i]) begin
            if (rx_cnt[i] >= FIFO_DEPTH) begin
              lsr_r[i] |= LSR_OE;
              overruns++;
            end else begin
              slot = (rx_rd[i] + rx_cnt[i]) % FIFO_DEPTH;
              rx_mem[i][slot] = it.rx_byte;
              lsr_r[i] = (lsr_r[i] & LSR_OE_CLEAR) | LSR_DR;
              rx_cnt[i]++;
            end
            if (ier_r[i][0]) begin
              rx_flag[i] = 1'b1;
              r.irq |= (i < 2) ? 2'b01 : 2'b10;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < UNIT_COUNT; i++) begin
          if (backlog[i] != 0) begin
            if (backlog[i] > cur_drain) backlog[i] -= cur_drain;
            else backlog[i] = '0;
            if (backlog[i] == 0) begin
              tx_flag[i] = 1'b1;
              lsr_r[i] |= LSR_THR_EMPTY;
              r.irq |= (i < 2) ? 2'b01 : 2'b10;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bus_item_t random_item();
    bus_item_t it;
    int pick;
    int u;
    ofs_e ofs;
    pick = $urandom_range(0, 99);
    u = $urandom_range(0, UNIT_COUNT - 1);
    ofs = ($urandom_range(0, 2) == 0) ? OFS_DATA : ofs_e'($urandom_range(0, 7));
    if (pick < 34) it.command = CMD_WRITE;
    else if (pick < 70) it.command = CMD_READ;
    else if (pick < 86) it.command = CMD_RX;
    else it.command = CMD_TICK;
    if ($urandom_range(0, 9) == 0) it.address = ADDR_W'($urandom_range(0, 16'hffff));
    else it.address = (cur_base[u] & BASE_MASK) | ADDR_W'(ofs);
    it.write_data = WDATA_W'($urandom_range(0, 16'hffff));
    // keep DLAB mostly clear so transmit and IER writes get through
    if (ofs == OFS_LCR && $urandom_range(0, 3) != 0) it.write_data[7] = 1'b0;
    it.rx_byte = BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input bus_item_t it, input logic pinned, input uart_result_t want);
    int gap;
    uart_result_t predicted;
    gap = gap_len(src_idle);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid      <= 1'b1;
    req.command    <= it.command;
    req.address    <= it.address;
    req.write_data <= it.write_data;
    req.rx_byte    <= it.rx_byte;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predicted = predict_uart_result(it);
    if (predicted.irq != 0) irq_pulses++;
    pending_results.push_back(pinned ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [UNIT_COUNT-1:0][ADDR_W-1:0] bases,
                            input logic [UNIT_COUNT-1:0] mask,
                            input logic [DRAIN_W-1:0] drain);
    for (int i = 0; i < UNIT_COUNT; i++) begin
      cur_base[i] = bases[i];
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(CFG_UNIT0_BASE + i);
      cfg_wdata_i <= bases[i];
      @(negedge clk_i);
    end
    cur_mask = mask;
    cfg_index_i <= CFG_RX_MASK;
    cfg_wdata_i <= CFG_DATA_W'(mask);
    @(negedge clk_i);
    cur_drain = drain;
    cfg_index_i <= CFG_DRAIN;
    cfg_wdata_i <= CFG_DATA_W'(drain);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  initial begin : sink_side
    int n;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      n = gap_len(sink_idle);
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    uart_result_t got;
    uart_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.accepted, rsp.read_data, rsp.tx_valid, rsp.tx_unit, rsp.tx_byte,
              rsp.irq_pulse};
      results_seen++;
      if (pending_results.size() == 0) begin
        if (errors < 10) $display("testbench: result item with nothing expected: %p", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (errors < 10) begin
            $display("testbench: mismatch at %0t: expected acc=%0b rd=%h txv=%0b txu=%0d",
                     $realtime, want.accepted, want.read_data, want.tx_valid, want.tx_unit);
            $display("  txb=%h irq=%b; got acc=%0b rd=%h txv=%0b txu=%0d txb=%h irq=%b",
                     want.tx_byte, want.irq, got.accepted, got.read_data, got.tx_valid,
                     got.tx_unit, got.tx_byte, got.irq);
          end
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: no handshake for %0d cycles", QUIET_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    bus_item_t it;
    logic [UNIT_COUNT-1:0][ADDR_W-1:0] bases;
    int u;
    bit rd_burst;

    req.valid      = 1'b0;
    req.command    = CMD_WRITE;
    req.address    = '0;
    req.write_data = '0;
    req.rx_byte    = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_UNIT0_BASE;
    cfg_wdata_i    = '0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    hold_req       = 1'b0;
    errors         = 0;
    items_sent     = 0;
    results_seen   = 0;
    overruns       = 0;
    irq_pulses     = 0;
    config_count   = 0;
    for (int i = 0; i < UNIT_COUNT; i++) begin
      cur_base[i] = BASE_RESET[i];
      ier_r[i]    = '0;
      lcr_r[i]    = '0;
      mcr_r[i]    = '0;
      lsr_r[i]    = LSR_RESET;
      scr_r[i]    = SCRATCH_RESET;
      rx_flag[i]  = 1'b0;
      tx_flag[i]  = 1'b0;
      backlog[i]  = '0;
      rx_rd[i]    = 0;
      rx_cnt[i]   = 0;
    end
    cur_mask  = RX_MASK_RESET;
    cur_drain = DRAIN_RESET;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    settle();

    // every unit listening: fill and overrun the receive FIFOs, then empty one
    set_config(BASE_RESET, 4'hf, DRAIN_RESET);
    repeat (FIFO_DEPTH + 4) begin
      it = '0;
      it.command = CMD_RX;
      it.rx_byte = BYTE_W'($urandom_range(0, 255));
      send_item(it, 1'b0, '0);
    end
    for (int i = 0; i < UNIT_COUNT; i++) begin
      it = '0;
      it.command = CMD_READ;
      it.address = BASE_RESET[i] | ADDR_W'(OFS_LSR);
      send_item(it, 1'b0, '0);
    end
    repeat (FIFO_DEPTH + 2) begin
      it = '0;
      it.command = CMD_READ;
      it.address = BASE_RESET[1] | ADDR_W'(OFS_DATA);
      send_item(it, 1'b0, '0);
    end
    it.address = BASE_RESET[1] | ADDR_W'(OFS_LSR);
    send_item(it, 1'b0, '0);
    settle();

    // transmit backlog on unit 2: forty writes drain in six ticks of seven
    src_idle = 1'b0;
    sink_idle = 1'b0;
    set_config(BASE_RESET, RX_MASK_RESET, 8'd7);
    it = '0;
    it.command = CMD_WRITE;
    it.address = BASE_RESET[2] | ADDR_W'(OFS_IER);
    it.write_data = 16'h0002;
    send_item(it, 1'b0, '0);
    repeat (BACKLOG_WRITES) begin
      it.address = BASE_RESET[2] | ADDR_W'(OFS_DATA);
      it.write_data = WDATA_W'($urandom_range(0, 16'hffff));
      send_item(it, 1'b0, '0);
    end
    it = '0;
    it.command = CMD_TICK;
    repeat (DRAIN_TICKS) send_item(it, 1'b0, '0);
    settle();

    // zero drain: a pending backlog stays put
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_config(BASE_RESET, RX_MASK_RESET, 8'd0);
    it = '0;
    it.command = CMD_WRITE;
    it.address = BASE_RESET[2] | ADDR_W'(OFS_DATA);
    it.write_data = 16'h00c3;
    send_item(it, 1'b0, '0);
    it.command = CMD_TICK;
    repeat (4) send_item(it, 1'b0, '0);
    it.command = CMD_READ;
    it.address = BASE_RESET[2] | ADDR_W'(OFS_ISR);
    send_item(it, 1'b0, '0);
    it.address = BASE_RESET[2] | ADDR_W'(OFS_LSR);
    send_item(it, 1'b0, '0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config({16'h1230, 16'hfff8, 16'h0008, 16'h0000}, 4'hf, 8'd1);
        1: set_config({16'h0040, 16'h0019, 16'hfff8, 16'hfff8}, 4'h0, 8'd255);
        default: begin
          for (int i = 0; i < UNIT_COUNT; i++) begin
            bases[i] = ADDR_W'($urandom_range(0, 16'hffff));
            if ($urandom_range(0, 4) != 0) bases[i] &= BASE_MASK;
          end
          set_config(bases, UNIT_COUNT'($urandom_range(0, 15)),
                     DRAIN_W'($urandom_range(0, 255)));
        end
      endcase
      src_idle  = (p != 2) && (p != 4);
      sink_idle = (p != 4);
      if (p == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) begin
          u = $urandom_range(0, UNIT_COUNT - 1);
          rd_burst = 1'($urandom_range(0, 1));
          repeat (20) begin
            it = '0;
            it.command = rd_burst ? CMD_READ : CMD_RX;
            it.address = (cur_base[u] & BASE_MASK) | ADDR_W'(OFS_DATA);
            it.rx_byte = BYTE_W'($urandom_range(0, 255));
            send_item(it, 1'b0, '0);
          end
        end else begin
          send_item(random_item(), 1'b0, '0);
        end
      end
      settle();
    end

    if (pending_results.size() != 0) begin
      $display("testbench: %0d result items never arrived", pending_results.size());
      errors++;
    end
    $display("testbench: %0d items sent, %0d result items checked, %0d unit layouts",
             items_sent, results_seen, config_count);
    $display("testbench: %0d receive overruns, %0d interrupt pulses, %0d failures",
             overruns, irq_pulses, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qurm_pkg.sv
rtl/qurm_if.sv
rtl/qurm_front.sv
rtl/qurm_queue.sv
rtl/qurm_back.sv
rtl/quad_uart_register_model_core.sv
sim/testbench.sv
